FILE: rtl/core/luhn_card_number_classifier_defines.svh
// Assertion macros used by the checker file of the card number classifier.
`ifndef LUHN_CARD_NUMBER_CLASSIFIER_DEFINES_SVH
`define LUHN_CARD_NUMBER_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define LCC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcc check failed");

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define LCC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcc check failed");

`endif

FILE: rtl/core/lcc_pkg.sv
// Shared types, constants and helper functions of the card number classifier.
`default_nettype none

package lcc_pkg;

    localparam int IN_W   = 63;
    localparam int DIG_W  = 4;
    localparam int DCNT_W = 5;
    localparam int CLS_W  = 3;

    typedef logic [DIG_W-1:0]  digit_t;
    typedef logic [DCNT_W-1:0] dcount_t;
    typedef logic [CLS_W-1:0]  class_t;
    typedef logic [7:0]        lead_t;   // two BCD digits, tens in the upper nibble

    typedef struct packed {
        logic clear;
        logic dabble;
        logic drain;
    } cell_ctrl_t;

    typedef struct packed {
        logic clear;
        logic step;
    } acc_ctrl_t;

    // leading digit pairs, BCD
    localparam lead_t PFX_37 = 8'h37;
    localparam lead_t PFX_30 = 8'h30;
    localparam lead_t PFX_40 = 8'h40;
    localparam lead_t PFX_41 = 8'h41;
    localparam lead_t PFX_49 = 8'h49;
    localparam lead_t PFX_42 = 8'h42;
    localparam lead_t PFX_22 = 8'h22;
    localparam lead_t PFX_55 = 8'h55;
    localparam lead_t PFX_51 = 8'h51;
    localparam lead_t PFX_52 = 8'h52;
    localparam lead_t PFX_35 = 8'h35;
    localparam lead_t PFX_60 = 8'h60;

    localparam dcount_t LEN_13 = 5'd13;
    localparam dcount_t LEN_14 = 5'd14;
    localparam dcount_t LEN_15 = 5'd15;
    localparam dcount_t LEN_16 = 5'd16;

    localparam class_t CLASS_NONE = 3'd0;
    localparam class_t CLASS_1    = 3'd1;
    localparam class_t CLASS_2    = 3'd2;
    localparam class_t CLASS_3    = 3'd3;
    localparam class_t CLASS_4    = 3'd4;
    localparam class_t CLASS_5    = 3'd5;
    localparam class_t CLASS_6    = 3'd6;

    // contribution of one digit to the Luhn sum, doubled on even positions
    function automatic digit_t luhn_term(input digit_t d, input logic dbl);
        logic [DIG_W:0] t;
        t = {d, 1'b0};
        if (!dbl)
            return d;
        else if (t >= 5'd10)
            return DIG_W'(t - 5'd9);
        else
            return t[DIG_W-1:0];
    endfunction

    function automatic class_t classify(input lead_t lead, input dcount_t cnt);
        if (lead == PFX_37 && cnt == LEN_15)
            return CLASS_1;
        else if (lead == PFX_30 && cnt == LEN_14)
            return CLASS_2;
        else if (((lead == PFX_40 || lead == PFX_41 || lead == PFX_49) && cnt == LEN_16) ||
                 (lead == PFX_42 && cnt == LEN_13))
            return CLASS_3;
        else if ((lead == PFX_22 || lead == PFX_55 || lead == PFX_51 || lead == PFX_52) &&
                 cnt == LEN_16)
            return CLASS_4;
        else if (lead == PFX_35 && cnt == LEN_16)
            return CLASS_5;
        else if (lead == PFX_60 && cnt == LEN_16)
            return CLASS_6;
        else
            return CLASS_NONE;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/lcc_digit_cell.sv
// One BCD digit cell: shift-add-3 step during conversion, shift toward cell 0 during drain.
`default_nettype none

module lcc_digit_cell
    import lcc_pkg::*;
(
    input  wire logic       clk,
    input  wire cell_ctrl_t ctrl,
    input  wire logic       bit_in,    // from the lower neighbor
    input  wire digit_t     digit_in,  // from the upper neighbor
    output logic            bit_out,
    output digit_t          digit
);

    digit_t digit_reg;
    digit_t digit_next;
    digit_t adj;

    always_comb
    begin
        adj = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
        if (ctrl.clear)
            digit_next = '0;
        else if (ctrl.dabble)
            digit_next = {adj[DIG_W-2:0], bit_in};
        else if (ctrl.drain)
            digit_next = digit_in;
        else
            digit_next = digit_reg;
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign bit_out = adj[DIG_W-1];
    assign digit   = digit_reg;

endmodule

`default_nettype wire

FILE: rtl/core/lcc_luhn_acc.sv
// Luhn sum, digit count and leading-pair tracker fed one digit per cycle; classifies at the end.
`default_nettype none

module lcc_luhn_acc
    import lcc_pkg::*;
#(
    parameter int MAX_DIGITS = 19
)
(
    input  wire logic                          clk,
    input  wire acc_ctrl_t                     ctrl,
    input  wire logic [$clog2(MAX_DIGITS)-1:0] idx,    // digit position, 0 = least significant
    input  wire digit_t                        digit,
    input  wire logic                          ovf,
    output class_t                             brand,
    output logic                               ok,
    output dcount_t                            count
);

    digit_t  sum_reg,   sum_next;     // Luhn sum mod 10
    dcount_t count_reg, count_next;
    digit_t  hi_reg,    hi_next;
    digit_t  lo_reg,    lo_next;
    digit_t  prev_reg,  prev_next;

    digit_t         term;
    logic [DIG_W:0] sum_raw;

    always_comb
    begin
        term       = luhn_term(digit, idx[0]);
        sum_raw    = {1'b0, sum_reg} + {1'b0, term};
        sum_next   = sum_reg;
        count_next = count_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        prev_next  = prev_reg;
        if (ctrl.clear)
        begin
            sum_next   = '0;
            count_next = '0;
            hi_next    = '0;
            lo_next    = '0;
            prev_next  = '0;
        end
        else if (ctrl.step)
        begin
            sum_next  = (sum_raw >= 5'd10) ? DIG_W'(sum_raw - 5'd10) : sum_raw[DIG_W-1:0];
            prev_next = digit;
            // highest nonzero digit so far sets length and leading pair
            if (digit != '0)
            begin
                count_next = DCNT_W'(idx) + 5'd1;
                hi_next    = digit;
                lo_next    = prev_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg   <= sum_next;
        count_reg <= count_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        prev_reg  <= prev_next;
    end

    assign ok    = (sum_reg == '0);
    assign count = ovf ? DCNT_W'(MAX_DIGITS) : count_reg;
    assign brand = (!ovf && ok) ? classify({hi_reg, lo_reg}, count_reg) : CLASS_NONE;

endmodule

`default_nettype wire

FILE: rtl/core/luhn_card_number_classifier.sv
// Top level of the Luhn card number checker and classifier.
`default_nettype none

// Usage
//   Input channel: card_number with card_valid / card_stall. An item is taken
//   at a clock edge with card_valid high and card_stall low. card_stall is
//   high while an item is being worked on.
//   Output channel: brand_class, luhn_ok, digit_count with result_valid /
//   result_stall. A result is held in an output register until taken, and a
//   new card number is accepted while it waits.
//   Work on one item: shift-add-3 conversion of all input bits through a
//   chain of MAX_DIGITS BCD cells (one input bit per cycle), then draining
//   the MAX_DIGITS digits out of cell 0 into the Luhn accumulator, then
//   classifying and loading the result into the output register. A new
//   card number is taken only once the previous one has been loaded there.
//   If the receiver stalls, the finished item waits in the classify step
//   until the output register is free; nothing is dropped.
//   Reset (rst_n low, asynchronous) returns to idle with no result pending.
//   Numbers wider than MAX_DIGITS digits report MAX_DIGITS, the Luhn result
//   of the low digits, and class 0.

module luhn_card_number_classifier
    import lcc_pkg::*;
#(
    parameter int MAX_DIGITS = 19
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [IN_W-1:0] card_number,
    input  wire logic            card_valid,
    output logic                 card_stall,
    output logic [CLS_W-1:0]     brand_class,
    output logic                 luhn_ok,
    output logic [DCNT_W-1:0]    digit_count,
    output logic                 result_valid,
    input  wire logic            result_stall
);

    localparam int IDX_W = $clog2(MAX_DIGITS);
    localparam int CNT_W = $clog2(IN_W);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(IN_W - 1);
    localparam logic [CNT_W-1:0] LAST_DIG = CNT_W'(MAX_DIGITS - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CONV  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic [IN_W-1:0]  num_reg,   num_next;
    logic             ovf_reg,   ovf_next;
    logic             vld_reg,   vld_next;
    class_t           brand_reg;
    logic             ok_reg;
    dcount_t          count_reg;

    logic       accept;
    logic       load;
    cell_ctrl_t cell_ctrl;
    acc_ctrl_t  acc_ctrl;

    logic [MAX_DIGITS:0] bit_c;              // carry chain, cell i -> cell i+1
    digit_t              digit_c [0:MAX_DIGITS]; // drain chain, cell i+1 -> cell i

    class_t  acc_brand;
    logic    acc_ok;
    dcount_t acc_count;

    assign accept = card_valid && !card_stall;
    assign load   = (state_reg == ST_DONE) && (!vld_reg || !result_stall);

    assign cell_ctrl.clear  = accept;
    assign cell_ctrl.dabble = (state_reg == ST_CONV);
    assign cell_ctrl.drain  = (state_reg == ST_DRAIN);
    assign acc_ctrl.clear   = accept;
    assign acc_ctrl.step    = (state_reg == ST_DRAIN);

    // MSB of the number enters the bottom cell first
    assign bit_c[0]            = num_reg[IN_W-1];
    assign digit_c[MAX_DIGITS] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_DIGITS; gi++)
        begin : g_cell
            lcc_digit_cell u_cell (
                .clk      (clk),
                .ctrl     (cell_ctrl),
                .bit_in   (bit_c[gi]),
                .digit_in (digit_c[gi+1]),
                .bit_out  (bit_c[gi+1]),
                .digit    (digit_c[gi])
            );
        end
    endgenerate

    lcc_luhn_acc #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_acc (
        .clk   (clk),
        .ctrl  (acc_ctrl),
        .idx   (cnt_reg[IDX_W-1:0]),
        .digit (digit_c[0]),
        .ovf   (ovf_reg),
        .brand (acc_brand),
        .ok    (acc_ok),
        .count (acc_count)
    );

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        num_next   = num_reg;
        ovf_next   = ovf_reg;
        vld_next   = vld_reg;
        if (vld_reg && !result_stall)
            vld_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    num_next   = card_number;
                    ovf_next   = 1'b0;
                    cnt_next   = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                num_next = {num_reg[IN_W-2:0], 1'b0};
                // a carry out of the top cell means more digits than cells
                ovf_next = ovf_reg | bit_c[MAX_DIGITS];
                if (cnt_reg == LAST_BIT)
                begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_DRAIN:
            begin
                if (cnt_reg == LAST_DIG)
                    state_next = ST_DONE;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_DONE:
            begin
                if (load)
                begin
                    vld_next   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            vld_reg   <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        if (load)
        begin
            brand_reg <= acc_brand;
            ok_reg    <= acc_ok;
            count_reg <= acc_count;
        end
    end

    assign card_stall   = (state_reg != ST_IDLE);
    assign result_valid = vld_reg;
    assign brand_class  = brand_reg;
    assign luhn_ok      = ok_reg;
    assign digit_count  = count_reg;

endmodule

`default_nettype wire

FILE: rtl/core/lcc_checker.sv
// Port-level checker for the card number classifier, bound to the top level.
`default_nettype none
`include "luhn_card_number_classifier_defines.svh"

module lcc_checker
    import lcc_pkg::*;
(
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            card_valid,
    input wire logic            card_stall,
    input wire logic [CLS_W-1:0] brand_class,
    input wire logic            luhn_ok,
    input wire logic [DCNT_W-1:0] digit_count,
    input wire logic            result_valid,
    input wire logic            result_stall
);

    logic card_acc;
    logic res_wait;

    assign card_acc = card_valid && !card_stall;
    assign res_wait = result_valid && result_stall;

    // busy right after taking an item
    `LCC_ASSERT_NEXT(a_busy_after_accept, card_acc, card_stall)
    // a result never appears the cycle after an item is taken
    `LCC_ASSERT_NEXT(a_no_instant_result, card_acc, !$rose(result_valid))
    // a class is only given to a valid card of legal length
    `LCC_ASSERT_SAME(a_class_legal, result_valid && brand_class != CLASS_NONE,
        luhn_ok && (digit_count == LEN_13 || digit_count == LEN_14 ||
                    digit_count == LEN_15 || digit_count == LEN_16))
    `LCC_ASSERT_NEXT(a_result_held, res_wait, result_valid)
    `LCC_ASSERT_NEXT(a_payload_held, res_wait,
        $stable(brand_class) && $stable(luhn_ok) && $stable(digit_count))

endmodule

bind luhn_card_number_classifier lcc_checker u_lcc_checker (.*);

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the Luhn card number classifier under random flow control.
module testbench;
    import lcc_pkg::*;

    // Converter depth handed to the DUT; the predictor peels the same number of digits.
    localparam int CARD_DIGITS = 19;
    // Long receiver hold-off, enough for the DUT to fill its output register and stall input.
    localparam int HOLD_CYCLES = 500;
    // Cycles with no item moving on either channel before the run is declared hung.
    // Worst honest gap: the hold-off, one full conversion and random stalls.
    localparam int QUIET_LIMIT = 4000;
    localparam int PHASE_ITEMS = 145;

    // One result item as the DUT reports it.
    typedef struct packed {
        class_t  brand;
        logic    luhn;
        dcount_t count;
    } verdict_t;

    // Keeps the verdicts predicted for accepted card numbers, oldest first.
    class card_verdicts;
        verdict_t awaited[$];
        int       errors;

        function new();
            errors = 0;
        endfunction

        // Digit walk, least significant first: odd positions add as is, even positions
        // add the doubled digit folded back below ten. Lead pair is kept in BCD.
        static function verdict_t verdict_of(logic [IN_W-1:0] number);
            longint unsigned rest;
            int unsigned     cnt;
            int unsigned     total;
            int unsigned     d;
            digit_t          prev;
            lead_t           lead;
            verdict_t        v;
            rest  = 64'(number);
            cnt   = 0;
            total = 0;
            prev  = '0;
            lead  = '0;
            while (rest != 0 && cnt < CARD_DIGITS)
            begin
                d    = 32'(rest % 10);
                rest = rest / 10;
                cnt++;
                if (cnt % 2 == 0)
                    total += (2 * d >= 10) ? 2 * d - 9 : 2 * d;
                else
                    total += d;
                lead = {digit_t'(d), prev};
                prev = digit_t'(d);
            end
            v.luhn  = (total % 10 == 0);
            v.count = dcount_t'(cnt);
            v.brand = CLASS_NONE;
            // digits left over mean the number was too long: never classified
            if (rest == 0 && v.luhn)
            begin
                if (v.count == LEN_16)
                begin
                    case (lead)
                        PFX_40, PFX_41, PFX_49:         v.brand = CLASS_3;
                        PFX_22, PFX_51, PFX_52, PFX_55: v.brand = CLASS_4;
                        PFX_35:                         v.brand = CLASS_5;
                        PFX_60:                         v.brand = CLASS_6;
                        default:                        v.brand = CLASS_NONE;
                    endcase
                end
                else if (v.count == LEN_15 && lead == PFX_37)
                    v.brand = CLASS_1;
                else if (v.count == LEN_14 && lead == PFX_30)
                    v.brand = CLASS_2;
                else if (v.count == LEN_13 && lead == PFX_42)
                    v.brand = CLASS_3;
            end
            return v;
        endfunction

        function void note_card(logic [IN_W-1:0] number);
            awaited.push_back(verdict_of(number));
        endfunction

        function void check_verdict(verdict_t got);
            verdict_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t: result with nothing awaited: expected none, got class %0d luhn %0d count %0d",
                         $time, got.brand, got.luhn, got.count);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.brand != want.brand)
            begin
                $display("%0t: brand_class expected %0d, got %0d", $time, want.brand, got.brand);
                errors++;
            end
            if (got.luhn != want.luhn)
            begin
                $display("%0t: luhn_ok expected %0d, got %0d", $time, want.luhn, got.luhn);
                errors++;
            end
            if (got.count != want.count)
            begin
                $display("%0t: digit_count expected %0d, got %0d", $time, want.count, got.count);
                errors++;
            end
        endfunction
    endclass

    logic            clk          = 1'b0;
    logic            rst_n        = 1'b0;
    logic [IN_W-1:0] card_number  = '0;
    logic            card_valid   = 1'b0;
    logic            result_stall = 1'b0;
    logic            card_stall;
    class_t          brand_class;
    logic            luhn_ok;
    dcount_t         digit_count;
    logic            result_valid;

    card_verdicts book;

    // Per-cycle idle odds in percent for the two sides, changed between phases.
    int send_gap_pct = 34;
    int recv_gap_pct = 65;

    // Hold-off request: the main process flips it, the receiver counts the cycles itself.
    logic hold_flip = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;

    int quiet = 0;

    // Prefix/length pairs that earn a class; lengths line up with the prefixes.
    lead_t   brand_leads[12] = '{PFX_37, PFX_30, PFX_40, PFX_41, PFX_49, PFX_42,
                                 PFX_22, PFX_51, PFX_52, PFX_55, PFX_35, PFX_60};
    dcount_t brand_lens[12]  = '{LEN_15, LEN_14, LEN_16, LEN_16, LEN_16, LEN_13,
                                 LEN_16, LEN_16, LEN_16, LEN_16, LEN_16, LEN_16};

    always #6 clk = ~clk;

    luhn_card_number_classifier #(
        .MAX_DIGITS (CARD_DIGITS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .card_number  (card_number),
        .card_valid   (card_valid),
        .card_stall   (card_stall),
        .brand_class  (brand_class),
        .luhn_ok      (luhn_ok),
        .digit_count  (digit_count),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

    // Builds a card number of len digits led by the BCD pair lead. The last digit is
    // picked so that the Luhn check passes when make_pass is set, random otherwise.
    function automatic logic [IN_W-1:0] make_card(lead_t lead, int unsigned len, bit make_pass);
        longint unsigned scale;
        longint unsigned n;
        int unsigned     i;
        int unsigned     c;
        scale = 1;
        for (i = 0; i < len - 2; i++)
            scale *= 10;
        n = (lead[7:4] * 10 + lead[3:0]) * scale + (({$urandom, $urandom}) % (scale / 10)) * 10;
        if (!make_pass)
            return IN_W'(n + $urandom_range(9));
        for (c = 0; c < 10; c++)
        begin
            if (card_verdicts::verdict_of(IN_W'(n + c)).luhn)
                return IN_W'(n + c);
        end
        return IN_W'(n);
    endfunction

    // Offers one card number, idling beforehand at the sender's odds, and returns at
    // the edge that takes it. Valid stays high into the next item when no idle follows.
    task automatic send_card(logic [IN_W-1:0] number);
        while ($urandom_range(99) < send_gap_pct)
        begin
            card_valid <= 1'b0;
            @(posedge clk);
        end
        card_valid  <= 1'b1;
        card_number <= number;
        @(posedge clk);
        while (card_stall)
            @(posedge clk);
    endtask

    // Receiver: random stalls, or a solid stretch of stalls when a hold-off is asked.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_flip != hold_seen)
            begin
                hold_seen = hold_flip;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= ($urandom_range(99) < recv_gap_pct);
        end
    end

    // Both channels are sampled at the edge, ahead of the drivers' updates for that edge.
    // The watchdog sits here too, since it needs to know whether anything moved.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (card_valid && !card_stall)
                book.note_card(card_number);
            if (result_valid && !result_stall)
                book.check_verdict({brand_class, luhn_ok, digit_count});
            if ((card_valid && !card_stall) || (result_valid && !result_stall))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
                $display("testbench: errors");
                $finish;
            end
        end
    end

    initial
    begin
        logic [IN_W-1:0] number;
        int              ph;
        int              k;
        int              pick;
        book = new();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (ph = 0; ph < 3; ph++)
        begin
            // sender busy / receiver slow, then the reverse, then full speed
            send_gap_pct = (ph == 0) ? 34 : (ph == 1) ? 65 : 0;
            recv_gap_pct = (ph == 0) ? 65 : (ph == 1) ? 34 : 0;

            if (ph == 0)
            begin
                // zero: no digits, Luhn sum of zero passes, still no class
                send_card('0);
                send_card(IN_W'(1));
                send_card(IN_W'(9));
                send_card(IN_W'(10));
                // every input bit set: 19 digits, longest walk
                send_card('1);
                send_card(IN_W'(64'd1000000000000000000));
                // one passing number for every classed prefix and length
                for (k = 0; k < 12; k++)
                    send_card(make_card(brand_leads[k], brand_lens[k], 1'b1));
                // good prefix but the wrong length: passes Luhn, no class
                send_card(make_card(PFX_37, 16, 1'b1));
                send_card(make_card(PFX_40, 13, 1'b1));
                send_card(make_card(PFX_42, 16, 1'b1));
                send_card(make_card(PFX_30, 12, 1'b1));
                send_card(make_card(PFX_60, 17, 1'b1));
                // good prefix and length, check digit off by one
                number = make_card(PFX_37, LEN_15, 1'b1);
                send_card(number - number % 10 + (number % 10 + 1) % 10);
            end

            // full-speed phase starts with a long receiver hold-off while items keep coming
            if (ph == 2)
                hold_flip <= ~hold_flip;

            repeat (PHASE_ITEMS)
            begin
                pick = $urandom_range(99);
                k    = $urandom_range(11);
                if (pick < 50)
                    number = make_card(brand_leads[k], brand_lens[k], $urandom_range(9) != 0);
                else if (pick < 60)
                    number = make_card(brand_leads[k], $urandom_range(12, 17), 1'b1);
                else if (pick < 72)
                    number = make_card({digit_t'($urandom_range(1, 9)), digit_t'($urandom_range(9))},
                                       $urandom_range(12, 17), 1'($urandom_range(1)));
                else if (pick < 86)
                    number = IN_W'({$urandom, $urandom});
                else
                    number = IN_W'({$urandom, $urandom}) >> $urandom_range(62);
                send_card(number);
            end

            // sender pauses until every result has come back
            card_valid <= 1'b0;
            do
                @(posedge clk);
            while (book.awaited.size() != 0);
        end

        // let a stray late result show up before judging
        repeat (100) @(posedge clk);

        if (book.errors == 0 && book.awaited.size() == 0)
            $display("testbench: clean");
        else
        begin
            if (book.awaited.size() != 0)
                $display("%0t: %0d results never arrived", $time, book.awaited.size());
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
